### src/bezier_arc_length_advance_unit_defines.svh
// Assertion macros shared by the arc-length advance RTL.
`ifndef BEZIER_ARC_LENGTH_ADVANCE_UNIT_DEFINES_SVH
`define BEZIER_ARC_LENGTH_ADVANCE_UNIT_DEFINES_SVH

// Check a property outside reset.
`define BALA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("bala assertion failed");

// Check a property on every edge, reset included.
`define BALA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("bala assertion failed");

`endif

### src/bala_pkg.sv
`default_nettype none
package bala_pkg;

  localparam int CW = 24;                       // coordinate width, Q16.8
  localparam int RW = 17;                       // ratio width, Q1.16
  localparam logic [RW-1:0] ONE_Q16 = 17'h10000;
  localparam int NUM_REGS = 8;
  localparam int DE_CAST_OPS = 9;               // ops of one de Casteljau pass

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [RW-1:0]        ratio_t;

  // Operation list of one coordinate pass over a four-tap shift line:
  // three lerps, drop, two lerps, drop, drop, final lerp.
  function automatic logic is_lerp(input logic [3:0] op);
    logic res;
    case (op)
      4'd3, 4'd6, 4'd7: res = 1'b0;
      default:          res = 1'b1;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

### src/bala_mul.sv
`default_nettype none
module bala_mul
  import bala_pkg::*;
(
  input  wire logic               clk,
  input  wire logic signed [24:0] op_a,
  input  wire logic signed [24:0] op_b,
  output logic signed [49:0]      prod_r
);

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule
`default_nettype wire

### src/bala_sqrt.sv
`default_nettype none
module bala_sqrt
  import bala_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [49:0] value,
  output logic             busy_r,
  output logic             done_r,
  output logic [24:0]      root_r
);

  logic [49:0] v_r;
  logic [26:0] rem_r;
  logic [4:0]  cnt_r;
  logic [28:0] rem_sh;
  logic [28:0] trial;
  logic        ge;

  // One result bit per cycle, two radicand bits consumed
  always_comb begin
    rem_sh = {rem_r, v_r[49:48]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        v_r    <= value;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        v_r <= {v_r[47:0], 2'b00};
        if (ge) begin
          rem_r  <= 27'(rem_sh - trial);
          root_r <= {root_r[23:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[26:0];
          root_r <= {root_r[23:0], 1'b0};
        end
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd24) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/bala_div.sv
`default_nettype none
module bala_div
  import bala_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [CW-1:0] num,
  input  wire logic [24:0]   den,
  output logic               busy_r,
  output logic               done_r,
  output ratio_t             quo_r
);

  logic [25:0] r_r;
  logic [24:0] den_r;
  logic [4:0]  cnt_r;
  logic        ge;
  logic [25:0] r_sub;

  // Restoring division, one quotient bit per cycle; num <= den keeps it in 17 bits
  always_comb begin
    ge    = (r_r >= {1'b0, den_r});
    r_sub = ge ? (r_r - {1'b0, den_r}) : r_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        r_r    <= {2'b00, num};
        den_r  <= den;
        quo_r  <= '0;
      end else if (busy_r) begin
        r_r   <= {r_sub[24:0], 1'b0};
        quo_r <= {quo_r[RW-2:0], ge};
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### src/bezier_arc_length_advance_unit.sv
// Arc-length advance along a cubic Bezier curve held in eight registers.
// Configuration: cfg_we writes cfg_data[23:0] to register cfg_index
// (p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y) on the clock edge.
// Input: in_start_ratio (Q1.16) and in_move_distance (Q16.8) transfer when
// in_valid and in_ready are high. One item is processed at a time.
// Output: out_new_ratio and out_reached_end transfer on out_valid/out_ready.
// Processing from the input transfer to out_valid: two coordinate passes for
// the start point through the shared registered 25x25 multiplier, a seek to
// the first mark, then for each chord two passes for the point, squaring,
// the bit-serial root and a compare, plus division and the result multiply
// and add in the final chord, or a direct finish when the curve runs out.
// The shared multiplier and the bit-serial root set how long this takes.
// in_ready rises together with out_valid, so a new item transfers only once
// the previous one has reached the output register.
// A result waits in the output register while the receiver stalls; the next
// input is taken meanwhile, and its result waits until the first leaves.
// Synchronous reset clears the control points to zero and drops any item.
`default_nettype none
`include "bezier_arc_length_advance_unit_defines.svh"
module bezier_arc_length_advance_unit
  import bala_pkg::*;
#(
  parameter int SEGMENTS = 10
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [CW-1:0] cfg_data,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [RW-1:0] in_start_ratio,
  input  wire logic [CW-1:0] in_move_distance,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [RW-1:0]      out_new_ratio,
  output logic               out_reached_end
);

  localparam int KW = $clog2(SEGMENTS + 2);
  localparam int MW = $clog2(SEGMENTS + 1);
  localparam logic [RW-1:0] STEP_Q = RW'(65536 / SEGMENTS);
  localparam logic [MW:0]   STEP_R = (MW + 1)'(65536 % SEGMENTS);

  typedef enum logic [3:0] {
    S_IDLE, S_SEEK, S_CHECK, S_LOAD, S_NEXT, S_LERP_MUL, S_LERP_ADD,
    S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT, S_CMP, S_DIV, S_RES_MUL, S_RES_ADD, S_DONE
  } state_t;

  state_t state_r;
  coord_t cfg_r [NUM_REGS];
  coord_t w_r [4];
  coord_t px_r, py_r, nx_r, ny_r;
  ratio_t t_r, mark_r, frac_r, res_r;
  logic [CW-1:0] remain_r;
  logic [KW-1:0] k_r, k0_r;
  logic [MW-1:0] mrem_r;
  logic [3:0]    op_r;
  logic          coord_r, first_r, end_r;
  logic          out_valid_r;
  logic [RW-1:0] out_ratio_r;
  logic          out_end_r;
  logic [49:0]   sq_x_r;

  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic [49:0]        sq_sum;
  logic               sqrt_start, sqrt_busy, sqrt_done;
  logic [24:0]        len;
  logic               div_start, div_busy, div_done;
  ratio_t             div_q;

  ratio_t             eval_t, start_sat;
  logic [RW+KW-1:0]   t_scaled;
  logic [MW:0]        mrem_sum;
  ratio_t             mark_adv;
  logic [MW-1:0]      mrem_adv;
  logic [33:0]        lerp_sh;
  coord_t             lerp_val;
  logic               fits;
  logic [RW:0]        res_sum;

  bala_mul u_mul (.clk(clk), .op_a(mul_a), .op_b(mul_b), .prod_r(prod));

  bala_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .value(sq_sum),
    .busy_r(sqrt_busy), .done_r(sqrt_done), .root_r(len)
  );

  bala_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .num(remain_r), .den(len),
    .busy_r(div_busy), .done_r(div_done), .quo_r(div_q)
  );

  // Saturate start, find first segment index
  always_comb begin
    start_sat = (in_start_ratio > ONE_Q16) ? ONE_Q16 : in_start_ratio;
    t_scaled  = (RW + KW)'(start_sat) * (RW + KW)'(SEGMENTS);
  end

  // Step the segment mark by 1/SEGMENTS with a carried remainder
  always_comb begin
    mrem_sum = {1'b0, mrem_r} + STEP_R;
    if (mrem_sum >= (MW + 1)'(SEGMENTS)) begin
      mrem_adv = MW'(mrem_sum - (MW + 1)'(SEGMENTS));
      mark_adv = mark_r + STEP_Q + RW'(1);
    end else begin
      mrem_adv = mrem_sum[MW-1:0];
      mark_adv = mark_r + STEP_Q;
    end
  end

  // Shared multiplier operand select
  always_comb begin
    eval_t = first_r ? t_r : mark_r;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      S_LERP_MUL: begin
        mul_a = {w_r[1][CW-1], w_r[1]} - {w_r[0][CW-1], w_r[0]};
        mul_b = {8'd0, eval_t};
      end
      S_SQ_X: begin
        mul_a = {nx_r[CW-1], nx_r} - {px_r[CW-1], px_r};
        mul_b = mul_a;
      end
      S_SQ_Y: begin
        mul_a = {ny_r[CW-1], ny_r} - {py_r[CW-1], py_r};
        mul_b = mul_a;
      end
      S_RES_MUL: begin
        mul_a = {8'd0, RW'(mark_r - t_r)};
        mul_b = {8'd0, frac_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Datapath helpers
  always_comb begin
    lerp_sh    = 34'((prod + 50'sd32768) >>> 16);
    lerp_val   = coord_t'(w_r[0] + lerp_sh[CW-1:0]);
    sq_sum     = sq_x_r + $unsigned(prod);
    fits       = ({1'b0, remain_r} <= len);
    res_sum    = {1'b0, t_r} + {1'b0, prod[32:16]};
    sqrt_start = (state_r == S_SQ_SUM);
    div_start  = (state_r == S_CMP) && fits && (len != '0);
    in_ready   = (state_r == S_IDLE);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) cfg_r[i] <= '0;
    end else if (cfg_we) begin
      cfg_r[cfg_index] <= cfg_data;
    end
  end

  // Sequencer and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      // drop the output once it transfers, unless a new result replaces it
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            t_r      <= start_sat;
            remain_r <= in_move_distance;
            k0_r     <= KW'(t_scaled >> 16) + KW'(1);
            k_r      <= '0;
            mark_r   <= '0;
            mrem_r   <= '0;
            first_r  <= 1'b1;
            coord_r  <= 1'b0;
            state_r  <= S_LOAD;
          end
        end
        S_SEEK: begin
          // advance mark until it belongs to k0
          if (k_r == k0_r) begin
            state_r <= S_CHECK;
          end else begin
            k_r    <= k_r + KW'(1);
            mark_r <= mark_adv;
            mrem_r <= mrem_adv;
          end
        end
        S_CHECK: begin
          if (k_r > KW'(SEGMENTS)) begin
            res_r   <= ONE_Q16;
            end_r   <= (remain_r != '0);
            state_r <= S_DONE;
          end else begin
            first_r <= 1'b0;
            coord_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          w_r[0]  <= cfg_r[{2'd0, coord_r}];
          w_r[1]  <= cfg_r[{2'd1, coord_r}];
          w_r[2]  <= cfg_r[{2'd2, coord_r}];
          w_r[3]  <= cfg_r[{2'd3, coord_r}];
          op_r    <= '0;
          state_r <= S_NEXT;
        end
        S_NEXT: begin
          if (op_r == 4'(DE_CAST_OPS)) begin
            // store the finished coordinate
            if (coord_r == 1'b0) begin
              if (first_r) px_r <= w_r[3];
              else         nx_r <= w_r[3];
              coord_r <= 1'b1;
              state_r <= S_LOAD;
            end else begin
              if (first_r) begin
                py_r    <= w_r[3];
                state_r <= S_SEEK;
              end else begin
                ny_r    <= w_r[3];
                state_r <= S_SQ_X;
              end
            end
          end else if (is_lerp(op_r)) begin
            state_r <= S_LERP_MUL;
          end else begin
            // drop the leading tap
            w_r[0] <= w_r[1];
            w_r[1] <= w_r[2];
            w_r[2] <= w_r[3];
            op_r   <= op_r + 4'd1;
          end
        end
        S_LERP_MUL: state_r <= S_LERP_ADD;
        S_LERP_ADD: begin
          w_r[0]  <= w_r[1];
          w_r[1]  <= w_r[2];
          w_r[2]  <= w_r[3];
          w_r[3]  <= lerp_val;
          op_r    <= op_r + 4'd1;
          state_r <= S_NEXT;
        end
        S_SQ_X: state_r <= S_SQ_Y;
        S_SQ_Y: begin
          sq_x_r  <= prod;
          state_r <= S_SQ_SUM;
        end
        S_SQ_SUM: state_r <= S_SQRT;
        S_SQRT: begin
          if (sqrt_done) state_r <= S_CMP;
        end
        S_CMP: begin
          if (fits) begin
            if (len == '0) begin
              frac_r  <= '0;
              state_r <= S_RES_MUL;
            end else begin
              state_r <= S_DIV;
            end
          end else begin
            // walk past this chord
            remain_r <= remain_r - len[CW-1:0];
            px_r     <= nx_r;
            py_r     <= ny_r;
            t_r      <= mark_r;
            k_r      <= k_r + KW'(1);
            mark_r   <= mark_adv;
            mrem_r   <= mrem_adv;
            state_r  <= S_CHECK;
          end
        end
        S_DIV: begin
          if (div_done) begin
            frac_r  <= div_q;
            state_r <= S_RES_MUL;
          end
        end
        S_RES_MUL: state_r <= S_RES_ADD;
        S_RES_ADD: begin
          res_r   <= (res_sum > {1'b0, ONE_Q16}) ? ONE_Q16 : res_sum[RW-1:0];
          end_r   <= 1'b0;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_ratio_r <= res_r;
            out_end_r   <= end_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_ratio   = out_ratio_r;
  assign out_reached_end = out_end_r;

  `BALA_ASSERT(a_ratio_max, out_valid_r |-> out_ratio_r <= ONE_Q16)
  `BALA_ASSERT(a_end_clamps, out_valid_r && out_end_r |-> out_ratio_r == ONE_Q16)
  `BALA_ASSERT(a_idle_units, state_r == S_IDLE |-> !sqrt_busy && !div_busy)
  `BALA_ASSERT(a_k_bound, k_r <= KW'(SEGMENTS + 1))
  `BALA_ASSERT_ALWAYS(a_reset_out, !rst_n |=> !out_valid_r)

endmodule
`default_nettype wire
